@@ design/tps_pkg.sv @@
package tps_pkg;

  // command bytes
  localparam logic [7:0] SYM_LEFT  = 8'd43;
  localparam logic [7:0] SYM_RIGHT = 8'd45;

  // rotation table length, CORDIC gain in Q30 and 2*pi in Q28
  localparam int unsigned TABLE_LEN   = 24;
  localparam logic signed [31:0] GAIN_Q30   = 32'sd652032874;
  localparam logic signed [31:0] TWO_PI_Q28 = 32'sd1686629713;

  // one beat inside the rotation chain
  typedef struct packed {
    logic               vld;
    logic [1:0]         quad;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } cordic_t;

  // per-move displacement handed to the accumulator
  typedef struct packed {
    logic               vld;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
  } step_t;

  // atan(2^-i) in 2^-32 turn units
  function automatic logic signed [31:0] atan_turn(input int unsigned idx);
    logic signed [31:0] t;
    case (idx)
      0:       t = 32'sd536870912;
      1:       t = 32'sd316933406;
      2:       t = 32'sd167458907;
      3:       t = 32'sd85004756;
      4:       t = 32'sd42667331;
      5:       t = 32'sd21354465;
      6:       t = 32'sd10679838;
      7:       t = 32'sd5340245;
      8:       t = 32'sd2670163;
      9:       t = 32'sd1335087;
      10:      t = 32'sd667544;
      11:      t = 32'sd333772;
      12:      t = 32'sd166886;
      13:      t = 32'sd83443;
      14:      t = 32'sd41722;
      15:      t = 32'sd20861;
      16:      t = 32'sd10430;
      17:      t = 32'sd5215;
      18:      t = 32'sd2608;
      19:      t = 32'sd1304;
      20:      t = 32'sd652;
      21:      t = 32'sd326;
      22:      t = 32'sd163;
      23:      t = 32'sd81;
      default: t = 32'sd0;
    endcase
    return t;
  endfunction

endpackage

@@ design/turtle_path_stepper_top.sv @@
// Turtle path stepper: takes one command byte per cycle while in_ready_o is
// high. '+' and '-' turn the heading by the configured step at once and give
// no output; any other byte moves the turtle one unit along its heading and
// yields one beat with the new saturated x,y position in signed fixed point
// (FRAC_BITS fraction bits). The sustained rate is one symbol per cycle while
// the output buffer is not full. A move passes the angle-prep register, loaded
// by the accepting edge, one cell per CORDIC rotation, four stages of fine
// correction, rounding and quadrant mapping, the position accumulator and the
// output buffer write before out_valid_o shows it. in_ready_o comes straight
// from the buffer fill count: it drops only while the two-entry output buffer
// is full, which freezes the whole chain. turn_step is written through
// cfg_we_i/cfg_wdata_i and should only change while no move is in flight.
module turtle_path_stepper_top #(
  parameter int unsigned ANGLE_BITS      = 16,
  parameter int unsigned FRAC_BITS       = 16,
  parameter int unsigned ROTATION_STAGES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic        [15:0] cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic         [7:0] symbol_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o
);
  import tps_pkg::*;

  localparam int unsigned LowPad = 32 - ANGLE_BITS;

  // saturate a 33-bit sum to the 32-bit signed range
  function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v[32] != v[31]) begin
      r = v[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  logic [15:0]               turn_step_q;
  logic [ANGLE_BITS-1:0]     heading_q, heading_d, step_ang;
  logic [ANGLE_BITS+15:0]    step_wide;
  logic                      adv;      // whole chain advances this cycle
  logic                      accept;
  logic                      is_move;

  // angle prep
  logic [31:0]               ang_full, ang_round, ang_res;
  logic [1:0]                ang_quad;
  cordic_t                   prep_d;
  cordic_t                   chain [ROTATION_STAGES+1];
  step_t                     step;

  // position accumulator
  logic signed [31:0]        pos_x_q, pos_y_q;
  logic                      acc_vld_q;
  logic                      buf_full;
  logic [31:0]               buf_x, buf_y;

  assign adv        = !buf_full;
  assign in_ready_o = adv;
  assign accept     = in_valid_i && in_ready_o;
  assign is_move    = (symbol_i != SYM_LEFT) && (symbol_i != SYM_RIGHT);

  // turn step reduced modulo one full turn
  assign step_wide = {{ANGLE_BITS{1'b0}}, turn_step_q};
  assign step_ang  = step_wide[ANGLE_BITS-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      turn_step_q <= '0;
    end else if (cfg_we_i) begin
      turn_step_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    heading_d = heading_q;
    if (accept) begin
      if (symbol_i == SYM_LEFT) begin
        heading_d = heading_q + step_ang;
      end else if (symbol_i == SYM_RIGHT) begin
        heading_d = heading_q - step_ang;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heading_q <= '0;
    end else begin
      heading_q <= heading_d;
    end
  end

  // heading as a 32-bit turn fraction, split into quadrant and residue
  assign ang_full  = {heading_q, {LowPad{1'b0}}};
  assign ang_round = ang_full + 32'h2000_0000;
  assign ang_quad  = ang_round[31:30];
  assign ang_res   = ang_full - {ang_quad, 30'd0};

  assign prep_d.vld  = accept && is_move;
  assign prep_d.quad = ang_quad;
  assign prep_d.x    = GAIN_Q30;
  assign prep_d.y    = 32'sd0;
  assign prep_d.z    = ang_res;

  // prep register at the head of the chain
  logic        prep_vld_q;
  logic [1:0]  prep_quad_q;
  logic [31:0] prep_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prep_vld_q <= 1'b0;
    end else if (adv) begin
      prep_vld_q <= prep_d.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      prep_quad_q <= prep_d.quad;
      prep_z_q    <= prep_d.z;
    end
  end

  assign chain[0].vld  = prep_vld_q;
  assign chain[0].quad = prep_quad_q;
  assign chain[0].x    = GAIN_Q30;
  assign chain[0].y    = 32'sd0;
  assign chain[0].z    = prep_z_q;

  // one rotation cell per CORDIC iteration
  for (genvar i = 0; i < ROTATION_STAGES; i++) begin : g_cell
    tps_cordic_cell #(
      .SHIFT (i)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .cell_i (chain[i]),
      .cell_o (chain[i+1])
    );
  end

  // residual-angle correction, rounding, quadrant mapping
  tps_fine_rotate #(
    .FRAC_BITS (FRAC_BITS)
  ) u_fine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .rot_i  (chain[ROTATION_STAGES]),
    .step_o (step)
  );

  // saturating position update, in symbol order
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q   <= '0;
      pos_y_q   <= '0;
      acc_vld_q <= 1'b0;
    end else if (adv) begin
      acc_vld_q <= step.vld;
      if (step.vld) begin
        pos_x_q <= sat32({pos_x_q[31], pos_x_q} + {step.dx[31], step.dx});
        pos_y_q <= sat32({pos_y_q[31], pos_y_q} + {step.dy[31], step.dy});
      end
    end
  end

  // output buffer decouples out_ready_i from in_ready_o
  tps_out_buffer u_obuf (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (adv && acc_vld_q),
    .push_x_i (pos_x_q),
    .push_y_i (pos_y_q),
    .full_o   (buf_full),
    .valid_o  (out_valid_o),
    .ready_i  (out_ready_i),
    .x_o      (buf_x),
    .y_o      (buf_y)
  );

  assign pos_x_o = buf_x;
  assign pos_y_o = buf_y;

endmodule

@@ design/tps_cordic_cell.sv @@
module tps_cordic_cell #(
  parameter int unsigned SHIFT = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  tps_pkg::cordic_t cell_i,
  output tps_pkg::cordic_t cell_o
);
  import tps_pkg::*;

  localparam logic signed [31:0] Angle = atan_turn(SHIFT);

  logic signed [31:0] x_in, y_in, z_in, x_sh, y_sh;
  logic signed [31:0] x_d, y_d, z_d;
  logic signed [31:0] x_q, y_q, z_q;
  logic [1:0]         quad_q;
  logic               vld_q;

  assign x_in = cell_i.x;
  assign y_in = cell_i.y;
  assign z_in = cell_i.z;
  assign x_sh = x_in >>> SHIFT;
  assign y_sh = y_in >>> SHIFT;

  always_comb begin
    if (!z_in[31]) begin
      x_d = x_in - y_sh;
      y_d = y_in + x_sh;
      z_d = z_in - Angle;
    end else begin
      x_d = x_in + y_sh;
      y_d = y_in - x_sh;
      z_d = z_in + Angle;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= cell_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q    <= x_d;
      y_q    <= y_d;
      z_q    <= z_d;
      quad_q <= cell_i.quad;
    end
  end

  assign cell_o.vld  = vld_q;
  assign cell_o.quad = quad_q;
  assign cell_o.x    = x_q;
  assign cell_o.y    = y_q;
  assign cell_o.z    = z_q;

endmodule

@@ design/tps_fine_rotate.sv @@
module tps_fine_rotate #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  tps_pkg::cordic_t rot_i,
  output tps_pkg::step_t   step_o
);
  import tps_pkg::*;

  localparam int unsigned RndShift = 30 - FRAC_BITS;
  localparam logic signed [32:0] RndHalf = 33'sd1 <<< (RndShift - 1);

  logic [3:0] vld_q;

  // stage a: residual angle to radians
  logic signed [31:0] z_in, a_x_q, a_y_q, a_zr_q;
  logic signed [63:0] zprod;
  logic [1:0]         a_quad_q;
  // stage b: cross products
  logic signed [63:0] b_px_q, b_py_q;
  logic signed [31:0] b_x_q, b_y_q;
  logic [1:0]         b_quad_q;
  // stage c: corrected vector
  logic signed [32:0] c_nx_d, c_ny_d, c_nx_q, c_ny_q;
  logic [1:0]         c_quad_q;
  // stage d: rounded and rotated into quadrant
  logic signed [32:0] rx_sum, ry_sum, rx_sh, ry_sh;
  logic signed [31:0] rc, rs, d_dx_d, d_dy_d, d_dx_q, d_dy_q;

  assign z_in  = rot_i.z;
  assign zprod = z_in * TWO_PI_Q28;

  assign c_nx_d = {b_x_q[31], b_x_q} - 33'(b_px_q >>> 30);
  assign c_ny_d = {b_y_q[31], b_y_q} + 33'(b_py_q >>> 30);

  assign rx_sum = c_nx_q + RndHalf;
  assign ry_sum = c_ny_q + RndHalf;
  assign rx_sh  = rx_sum >>> RndShift;
  assign ry_sh  = ry_sum >>> RndShift;
  assign rc     = rx_sh[31:0];
  assign rs     = ry_sh[31:0];

  always_comb begin
    case (c_quad_q)
      2'd0: begin
        d_dx_d = rc;
        d_dy_d = rs;
      end
      2'd1: begin
        d_dx_d = -rs;
        d_dy_d = rc;
      end
      2'd2: begin
        d_dx_d = -rc;
        d_dy_d = -rs;
      end
      default: begin
        d_dx_d = rs;
        d_dy_d = -rc;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], rot_i.vld};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_zr_q   <= zprod[61:30];
      a_x_q    <= rot_i.x;
      a_y_q    <= rot_i.y;
      a_quad_q <= rot_i.quad;
      b_px_q   <= a_y_q * a_zr_q;
      b_py_q   <= a_x_q * a_zr_q;
      b_x_q    <= a_x_q;
      b_y_q    <= a_y_q;
      b_quad_q <= a_quad_q;
      c_nx_q   <= c_nx_d;
      c_ny_q   <= c_ny_d;
      c_quad_q <= b_quad_q;
      d_dx_q   <= d_dx_d;
      d_dy_q   <= d_dy_d;
    end
  end

  assign step_o.vld = vld_q[3];
  assign step_o.dx  = d_dx_q;
  assign step_o.dy  = d_dy_q;

endmodule

@@ design/tps_out_buffer.sv @@
module tps_out_buffer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  logic [31:0] push_x_i,
  input  logic [31:0] push_y_i,
  output logic        full_o,
  output logic        valid_o,
  input  logic        ready_i,
  output logic [31:0] x_o,
  output logic [31:0] y_o
);

  logic [1:0]  cnt_q, cnt_d;
  logic        wr_ptr_q, rd_ptr_q;
  logic [31:0] mem_x_q [2];
  logic [31:0] mem_y_q [2];
  logic        pop;

  assign pop     = valid_o && ready_i;
  assign valid_o = (cnt_q != 2'd0);
  assign full_o  = (cnt_q == 2'd2);
  assign x_o     = mem_x_q[rd_ptr_q];
  assign y_o     = mem_y_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_x_q[wr_ptr_q] <= push_x_i;
      mem_y_q[wr_ptr_q] <= push_y_i;
    end
  end

endmodule

@@ design/tps_checker.sv @@
module tps_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] pos_x_o,
  input logic [31:0] pos_y_o
);

  // stalled result holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pos_x_o) && $stable(pos_y_o))
    else $error("output beat changed while stalled");

  // input is only blocked while results are waiting
  a_block_has_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input blocked with no output pending");

  // blocking only starts after a stalled output
  a_block_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_ready_o) |-> $past(out_valid_o && !out_ready_i))
    else $error("input blocked without output stall");

  // one taken output frees the input side
  a_unblock: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o && out_ready_i |=> in_ready_o)
    else $error("input still blocked after output drained");

endmodule

bind turtle_path_stepper_top tps_checker u_tps_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .pos_x_o     (pos_x_o),
  .pos_y_o     (pos_y_o)
);
